// File: hw/rtl/tmsq_pkg.sv
// Package with the request, result and configuration types of the SDU queue.
package tmsq_pkg;

    // Request operation codes.
    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_TXOPP   = 2'd1;
    localparam logic [1:0] OP_FLUSH   = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    // Result kinds.
    localparam logic [2:0] RK_OCCUPANCY = 3'd0;
    localparam logic [2:0] RK_SELECTED  = 3'd1;
    localparam logic [2:0] RK_NONE      = 3'd2;
    localparam logic [2:0] RK_FULL      = 3'd3;
    localparam logic [2:0] RK_FLUSHED   = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BROADCAST  = 2'd0;
    localparam logic [1:0] CFG_SLOT_DELTA = 2'd1;
    localparam logic [1:0] CFG_MAX_AGE    = 2'd2;

    localparam int unsigned CFG_DATA_W = 14;
    localparam logic [13:0] TICK_WRAP  = 14'd10240;
    localparam logic [4:0]  SLOTS_PER_FRAME = 5'd10;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] sdu_rnti;
        logic [9:0]  sdu_sfn;
        logic [3:0]  sdu_slot;
        logic [14:0] sdu_length;
        logic [15:0] sdu_handle;
        logic [17:0] trans_id;
        logic [13:0] cur_time;
    } t_req;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [15:0] out_rnti;
        logic [9:0]  out_sfn;
        logic [3:0]  out_slot;
        logic [14:0] out_length;
        logic [15:0] out_handle;
        logic [4:0]  discarded_count;
    } t_rsp;

    // One stored descriptor.
    typedef struct packed {
        logic [15:0] rnti;
        logic [9:0]  sfn;
        logic [3:0]  slot;
        logic [13:0] arrival;
        logic [14:0] length;
        logic [15:0] handle;
    } t_entry;

    // Match criteria handed to the entry checker.
    typedef struct packed {
        logic        bcast;
        logic [9:0]  frame;
        logic [3:0]  tslot;
        logic [15:0] rnti;
        logic [13:0] now;
        logic [13:0] max_age;
    } t_crit;

    // Verdict on one entry.
    typedef struct packed {
        logic discard;
        logic pick;
    } t_verdict;

endpackage

// File: hw/rtl/tmsq_check.sv
// Shared compare unit that judges one queue entry against the match criteria.
module tmsq_check (
    input  tmsq_pkg::t_entry   i_entry,
    input  tmsq_pkg::t_crit    i_crit,
    output tmsq_pkg::t_verdict o_verdict
);
    import tmsq_pkg::*;

    logic [15:0] age;

    // Age with wrap of the tick counter. A stamp beyond the wrap point can make
    // the wrapped age negative; bit 15 then marks it as never stale.
    always_comb begin
        if (i_crit.now < i_entry.arrival) begin
            age = 16'(TICK_WRAP) - 16'(i_entry.arrival) + 16'(i_crit.now);
        end else begin
            age = 16'(i_crit.now) - 16'(i_entry.arrival);
        end
    end

    // Broadcast discards mismatching heads; dedicated drops stale entries.
    always_comb begin
        if (i_crit.bcast) begin
            o_verdict.pick    = (i_entry.sfn == i_crit.frame) && (i_entry.slot == i_crit.tslot);
            o_verdict.discard = !o_verdict.pick;
        end else begin
            o_verdict.discard = !age[15] && (age[14:0] > 15'(i_crit.max_age));
            o_verdict.pick    = !o_verdict.discard && (i_entry.rnti == i_crit.rnti);
        end
    end
endmodule

// File: hw/rtl/tm_sdu_queue_select_top.sv
// Top level of the transparent-mode SDU queue with its walk sequencer.
// Usage: a request is taken when i_start is high and o_busy is low. Enqueue,
// flush and queue-full requests pass through S_RESP, which raises o_done. A
// transmit opportunity walks the queue through a single compare unit,
// compacting kept entries in place through the one write port of the
// descriptor memory. The memory read is registered, so each entry is read in
// S_READ and then judged and moved in S_WALK. o_busy is high for the whole
// request, including the cycle that o_done is high.
// Each result is on o_rsp for the one cycle that o_done is high; the receiver
// cannot stall it. The user must write configuration through i_cfg_we,
// i_cfg_idx and i_cfg_data only while idle; the block does not enforce this.
// Reset empties the queue and loads register defaults: dedicated mode, slot
// delta 1, max age 40. The descriptor memory itself is not cleared; only
// entries below the count are read. Opcode 3 is accepted and gives no result.
module tm_sdu_queue_select_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  tmsq_pkg::t_req             i_req,
    output logic                       o_busy,
    output logic                       o_done,
    output tmsq_pkg::t_rsp             o_rsp,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [tmsq_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tmsq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_WALK, S_RESP} t_state;

    t_state        r_state;
    logic [CW-1:0] r_count, r_rd, r_wr;
    logic [4:0]    r_disc;
    logic          r_found;
    t_entry        r_pick;
    t_crit         r_crit;
    t_rsp          r_rsp;
    logic          r_done;
    logic          r_bcast;
    logic [3:0]    r_slot_delta;
    logic [13:0]   r_max_age;

    t_entry        mem [QUEUE_DEPTH];
    t_entry        r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_entry        mem_wdata;
    t_verdict      verdict;
    logic [8:0]    slot_sum;
    logic [15:0]   slot_prod;
    logic [4:0]    slot_q;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcast      <= 1'b0;
            r_slot_delta <= 4'd1;
            r_max_age    <= 14'd40;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BROADCAST:  r_bcast      <= i_cfg_data[0];
                CFG_SLOT_DELTA: r_slot_delta <= i_cfg_data[3:0];
                CFG_MAX_AGE:    r_max_age    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tmsq_check u_check (.i_entry(r_rdata), .i_crit(r_crit), .o_verdict(verdict));

    assign slot_sum = 9'(i_req.trans_id[7:0]) + 9'(r_slot_delta);

    // Slot sum divided by ten through a reciprocal multiply, exact for sums up to 319.
    assign slot_prod = 16'(slot_sum) * 16'd205;
    assign slot_q    = slot_prod[15:11];

    // Memory write port: enqueue or compaction during the walk.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wr[AW-1:0];
        mem_wdata = r_rdata;
        mem_raddr = r_rd[AW-1:0];
        if (r_state == S_IDLE && !r_done && i_start && i_req.opcode == OP_ENQUEUE
            && r_count < CW'(QUEUE_DEPTH)) begin
            mem_we    = 1'b1;
            mem_waddr = r_count[AW-1:0];
            mem_wdata = '{rnti: i_req.sdu_rnti, sfn: i_req.sdu_sfn,
                          slot: i_req.sdu_slot, arrival: i_req.cur_time,
                          length: i_req.sdu_length, handle: i_req.sdu_handle};
        end else if (r_state == S_WALK && (r_found || (!verdict.discard && !verdict.pick))) begin
            mem_we = 1'b1;
        end
    end

    // Descriptor memory.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // Sequencer and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_rd    <= '0;
            r_wr    <= '0;
            r_disc  <= '0;
            r_found <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start && !r_done) begin
                        r_rsp <= '0;
                        case (i_req.opcode)
                            OP_ENQUEUE: begin
                                r_state <= S_RESP;
                                if (r_count < CW'(QUEUE_DEPTH)) begin
                                    r_count <= r_count + 1'b1;
                                    r_rsp.result_kind <= RK_OCCUPANCY;
                                    r_rsp.out_length  <= i_req.sdu_length;
                                end else begin
                                    r_rsp.result_kind <= RK_FULL;
                                end
                            end
                            OP_FLUSH: begin
                                r_count <= '0;
                                r_rsp.result_kind <= RK_FLUSHED;
                                r_state <= S_RESP;
                            end
                            OP_TXOPP: begin
                                r_crit.bcast   <= r_bcast;
                                r_crit.rnti    <= i_req.sdu_rnti;
                                r_crit.now     <= i_req.cur_time;
                                r_crit.max_age <= r_max_age;
                                if (slot_sum >= 9'(SLOTS_PER_FRAME)) begin
                                    r_crit.frame <= i_req.trans_id[17:8] + 10'd1;
                                end else begin
                                    r_crit.frame <= i_req.trans_id[17:8];
                                end
                                r_crit.tslot <= 4'(slot_sum - 9'(slot_q) * 9'd10);
                                r_rd    <= '0;
                                r_wr    <= '0;
                                r_disc  <= '0;
                                r_found <= 1'b0;
                                r_pick  <= '0;
                                r_state <= S_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    // Memory read of the current entry is in flight.
                    if (r_rd >= r_count) begin
                        r_count <= r_wr;
                        r_rsp.discarded_count <= r_disc;
                        if (r_found) begin
                            r_rsp.result_kind <= RK_SELECTED;
                            r_rsp.out_rnti    <= r_pick.rnti;
                            r_rsp.out_sfn     <= r_pick.sfn;
                            r_rsp.out_slot    <= r_pick.slot;
                            r_rsp.out_length  <= r_pick.length;
                            r_rsp.out_handle  <= r_pick.handle;
                        end else begin
                            r_rsp.result_kind <= RK_NONE;
                        end
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_found || (!verdict.discard && !verdict.pick)) begin
                        r_wr <= r_wr + 1'b1;
                    end else if (verdict.discard) begin
                        r_disc <= r_disc + 5'd1;
                    end else begin
                        r_found <= 1'b1;
                        r_pick  <= r_rdata;
                    end
                    r_rd    <= r_rd + 1'b1;
                    r_state <= S_READ;
                end
                S_RESP: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE) || r_done;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // The queue never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH)) else $error("queue count above depth");
    // Compaction never overtakes the read pointer.
    a_wr_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr <= r_rd) else $error("write pointer ahead of read pointer");
    // A result always follows the response state.
    a_done_after_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RESP |=> o_done) else $error("missing result strobe");
endmodule

// File: verif/tm_sdu_queue_select_top_tb.sv
// Self-checking testbench for the transparent-mode SDU queue top level.
`timescale 1ns / 100ps

module tm_sdu_queue_select_top_tb;
    import tmsq_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_start;
    t_req            i_req;
    logic            o_busy;
    logic            o_done;
    t_rsp            o_rsp;
    logic            i_cfg_we;
    logic [1:0]      i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tm_sdu_queue_select_top #(.QUEUE_DEPTH(DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_req(i_req),
        .o_busy(o_busy), .o_done(o_done), .o_rsp(o_rsp),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the queue and the registers.
    t_entry      shadow_q[DEPTH];
    int          shadow_count;
    logic        mode_bcast;
    logic [3:0]  mode_delta;
    logic [13:0] mode_max_age;

    t_rsp        pending_rsp[$];
    int          fail_count;
    int          cycle_count = 0;
    int          burst_left;

    // Stimulus state: dedicated tick and broadcast frame/slot cursor.
    int          tick;
    int          bc_frame;
    int          bc_slot;
    logic [15:0] rnti_pool[4];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_rsp.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Work out the result of one request and update the shadow queue.
    function automatic bit predict_rsp(input t_req r, output t_rsp rsp);
        int frame, tslot, age, w, discards;
        bit found;
        t_entry pick;
        rsp = '0;
        if (r.opcode == OP_ENQUEUE) begin
            if (shadow_count >= DEPTH) begin
                rsp.result_kind = RK_FULL;
                return 1'b1;
            end
            shadow_q[shadow_count] = '{r.sdu_rnti, r.sdu_sfn, r.sdu_slot, r.cur_time,
                                       r.sdu_length, r.sdu_handle};
            shadow_count++;
            rsp.result_kind = RK_OCCUPANCY;
            rsp.out_length  = r.sdu_length;
            return 1'b1;
        end
        if (r.opcode == OP_FLUSH) begin
            shadow_count = 0;
            rsp.result_kind = RK_FLUSHED;
            return 1'b1;
        end
        if (r.opcode != OP_TXOPP) return 1'b0;

        w = 0;
        discards = 0;
        found = 1'b0;
        pick = '0;
        frame = r.trans_id[17:8];
        tslot = r.trans_id[7:0] + mode_delta;
        if (tslot >= 10) frame = (frame + 1) % 1024;
        tslot = tslot % 10;
        for (int i = 0; i < shadow_count; i++) begin
            if (found) begin
                shadow_q[w++] = shadow_q[i];
            end else if (mode_bcast) begin
                if (shadow_q[i].sfn != frame || shadow_q[i].slot != tslot) begin
                    discards++;
                end else begin
                    pick = shadow_q[i];
                    found = 1'b1;
                end
            end else begin
                if (r.cur_time < shadow_q[i].arrival)
                    age = (10240 - int'(shadow_q[i].arrival)) + int'(r.cur_time);
                else
                    age = int'(r.cur_time) - int'(shadow_q[i].arrival);
                if (age > int'(mode_max_age)) begin
                    discards++;
                end else if (shadow_q[i].rnti != r.sdu_rnti) begin
                    shadow_q[w++] = shadow_q[i];
                end else begin
                    pick = shadow_q[i];
                    found = 1'b1;
                end
            end
        end
        shadow_count = w;
        rsp.discarded_count = discards[4:0];
        if (!found) begin
            rsp.result_kind = RK_NONE;
            return 1'b1;
        end
        rsp.result_kind = RK_SELECTED;
        rsp.out_rnti    = pick.rnti;
        rsp.out_sfn     = pick.sfn;
        rsp.out_slot    = pick.slot;
        rsp.out_length  = pick.length;
        rsp.out_handle  = pick.handle;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Compare every result with the oldest expectation.
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && o_done) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_rsp);
                fail_count++;
            end else begin
                e = pending_rsp.pop_front();
                check_field("result_kind", e.result_kind, o_rsp.result_kind);
                check_field("out_rnti", e.out_rnti, o_rsp.out_rnti);
                check_field("out_sfn", e.out_sfn, o_rsp.out_sfn);
                check_field("out_slot", e.out_slot, o_rsp.out_slot);
                check_field("out_length", e.out_length, o_rsp.out_length);
                check_field("out_handle", e.out_handle, o_rsp.out_handle);
                check_field("discarded_count", e.discarded_count, o_rsp.discarded_count);
            end
        end
    end

    // Send one request, with random bursts and gaps in between.
    task automatic send_req(input t_req r);
        t_rsp e;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        burst_left--;
        @(posedge i_clk);
        i_start <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy);
        i_start <= 1'b0;
        if (predict_rsp(r, e)) pending_rsp.push_back(e);
    endtask

    // Wait until every expected result is in and the block is quiet.
    task automatic drain;
        while (pending_rsp.size() != 0 || o_busy) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input int value);
        drain();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BROADCAST:  mode_bcast   = value[0];
            CFG_SLOT_DELTA: mode_delta   = value[3:0];
            CFG_MAX_AGE:    mode_max_age = value[13:0];
            default: ;
        endcase
    endtask

    function automatic t_req make_enq(input logic [15:0] rnti, input int sfn, input int slot,
                                      input int now);
        t_req r;
        r = '0;
        r.opcode     = OP_ENQUEUE;
        r.sdu_rnti   = rnti;
        r.sdu_sfn    = sfn[9:0];
        r.sdu_slot   = slot[3:0];
        r.sdu_length = 15'($urandom);
        r.sdu_handle = 16'($urandom);
        r.trans_id   = 18'($urandom);
        r.cur_time   = now[13:0];
        return r;
    endfunction

    function automatic t_req make_opp(input logic [15:0] rnti, input int frame, input int slot,
                                      input int now);
        t_req r;
        r = '0;
        r.opcode     = OP_TXOPP;
        r.sdu_rnti   = rnti;
        r.sdu_sfn    = 10'($urandom);
        r.sdu_slot   = 4'($urandom);
        r.sdu_length = 15'($urandom);
        r.sdu_handle = 16'($urandom);
        r.trans_id   = {frame[9:0], slot[7:0]};
        r.cur_time   = now[13:0];
        return r;
    endfunction

    function automatic t_req make_op(input logic [1:0] op);
        t_req r;
        r = t_req'({$urandom, $urandom, $urandom});
        r.opcode   = op;
        r.cur_time = 14'($urandom_range(0, 10239));
        return r;
    endfunction

    // Reset defaults, field extremes, full queue, flush and the unused opcode.
    task automatic test_directed;
        t_req r;
        send_req(make_enq(16'h0000, 0, 0, 0));
        send_req(make_enq(16'hFFFF, 1023, 15, 10239));
        r = make_enq(16'h1234, 5, 5, 10239);
        r.sdu_length = 15'h7FFF;
        r.sdu_handle = 16'hFFFF;
        send_req(r);
        // Tick wrap: arrival 10239, now 20 gives age 21, within the default age.
        send_req(make_opp(16'h1234, 0, 0, 20));
        // Both other entries are stale at the far end of the tick range.
        send_req(make_opp(16'hFFFF, 0, 0, 5000));
        send_req(make_op(OP_UNUSED));
        for (int i = 0; i < DEPTH + 2; i++) send_req(make_enq(16'h0042, i, i % 10, 100));
        send_req(make_opp(16'h0042, 0, 0, 140));
        send_req(make_opp(16'h0042, 0, 0, 141));
        send_req(make_op(OP_FLUSH));
        send_req(make_opp(16'h0042, 0, 0, 141));
    endtask

    // Broadcast matching with frame wrap and out-of-range slot bytes.
    task automatic test_broadcast_directed;
        write_cfg(CFG_BROADCAST, 1);
        write_cfg(CFG_SLOT_DELTA, 9);
        send_req(make_enq(16'h0001, 0, 8, 0));
        send_req(make_enq(16'h0002, 0, 3, 0));
        send_req(make_enq(16'h0003, 1, 2, 0));
        // Slot 9 plus 9 wraps the frame from 1023 to 0 and gives slot 8.
        send_req(make_opp(16'h0000, 1023, 9, 0));
        send_req(make_opp(16'h0000, 0, 255, 0));
        write_cfg(CFG_SLOT_DELTA, 0);
        send_req(make_enq(16'h0004, 7, 0, 0));
        send_req(make_opp(16'h0000, 7, 0, 0));
    endtask

    function automatic t_req next_dedicated;
        int pick;
        logic [15:0] rnti;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) tick = $urandom_range(0, 10239);
        else tick = (tick + $urandom_range(0, 12)) % 10240;
        rnti = ($urandom_range(0, 9) == 0) ? 16'($urandom) : rnti_pool[$urandom_range(0, 3)];
        if (pick < 48) return make_enq(rnti, $urandom_range(0, 1023), $urandom_range(0, 15),
                                       tick);
        if (pick < 94) return make_opp(rnti, $urandom_range(0, 1023), $urandom_range(0, 255),
                                       tick);
        if (pick < 97) return make_op(OP_FLUSH);
        return make_op(OP_UNUSED);
    endfunction

    function automatic t_req next_broadcast;
        int pick, ahead, s;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            // Aim the SDU at one of the next few opportunities, sometimes off target.
            ahead = $urandom_range(0, 3);
            s = bc_slot + ahead + mode_delta;
            if ($urandom_range(0, 7) == 0)
                return make_enq(16'($urandom), $urandom_range(0, 1023), $urandom_range(0, 15),
                                tick);
            return make_enq(16'($urandom), (bc_frame + s / 10) % 1024, s % 10, tick);
        end
        if (pick < 95) begin
            if ($urandom_range(0, 15) == 0)
                return make_opp(16'($urandom), $urandom_range(0, 1023), $urandom_range(0, 255),
                                tick);
            bc_slot++;
            if (bc_slot == 10) begin
                bc_slot = 0;
                bc_frame = (bc_frame + 1) % 1024;
            end
            return make_opp(16'($urandom), bc_frame, bc_slot, tick);
        end
        if (pick < 98) return make_op(OP_FLUSH);
        return make_op(OP_UNUSED);
    endfunction

    task automatic test_dedicated_random(input int n, input int age);
        write_cfg(CFG_BROADCAST, 0);
        write_cfg(CFG_MAX_AGE, age);
        for (int i = 0; i < n; i++) send_req(next_dedicated());
    endtask

    task automatic test_broadcast_random(input int n, input int delta);
        write_cfg(CFG_BROADCAST, 1);
        write_cfg(CFG_SLOT_DELTA, delta);
        bc_frame = (tick % 2) ? 1020 : $urandom_range(0, 1023);
        bc_slot = $urandom_range(0, 9);
        for (int i = 0; i < n; i++) send_req(next_broadcast());
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_BROADCAST;
        i_cfg_data = '0;
        fail_count = 0;
        burst_left = 0;
        shadow_count = 0;
        mode_bcast = 1'b0;
        mode_delta = 4'd1;
        mode_max_age = 14'd40;
        tick = 0;
        rnti_pool = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'h00A1};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_broadcast_directed();
        test_dedicated_random(250, 40);
        test_dedicated_random(150, 0);
        test_dedicated_random(150, 10239);
        test_broadcast_random(200, 1);
        test_broadcast_random(150, 0);
        test_broadcast_random(150, 9);
        test_dedicated_random(200, $urandom_range(1, 200));

        drain();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
